// ===== hw/rtl/grwf_pkg.sv =====
// shared types and constants for the gradient ratio weather filter
package grwf_pkg;

  localparam int MaxWidth = 512;
  localparam int MaxHeight = 1024;
  localparam int FracBits = 15;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);
  localparam int GW = 16;
  localparam int AddrW = 3;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  // one quotient bit per fraction bit, the remainder starts at the difference
  localparam int DivSteps = FracBits;

  typedef enum logic [AddrW-1:0] {
    RegWidth   = 3'd0,
    RegHeight  = 3'd1,
    RegLim37   = 3'd2,
    RegLim22   = 3'd3,
    RegWeather = 3'd4,
    RegBad     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] t19;
    logic [15:0] t22;
    logic [15:0] t37;
    logic [7:0]  conc;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic        has_prev;
    logic        is_last_row;
  } job_t;

  typedef struct packed {
    logic [7:0]  conc;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [1:0]  c37;
    logic        c22;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    BkIdle = 2'd0,
    BkDiv  = 2'd1,
    BkRead = 2'd2,
    BkOut  = 2'd3
  } bk_state_e;

endpackage

// ===== hw/rtl/grwf_ram.sv =====
// generic single port write, single port registered read ram
module grwf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hw/rtl/grwf_front.sv =====
// front end: position tracking, item classification and job queue
module grwf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [55:0]                 in_data_i,
  input  logic                        frame_start_i,
  input  logic [9:0]                  width_i,
  input  logic [10:0]                 height_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output grwf_pkg::job_t              job_o
);
  logic [grwf_pkg::ColW:0] w_eff;
  logic [grwf_pkg::RowW:0] h_eff;
  logic [grwf_pkg::ColW:0] col_q, col_d, c;
  logic [grwf_pkg::RowW:0] row_q, row_d, r;
  logic [grwf_pkg::ColW:0] cn;
  logic [grwf_pkg::RowW:0] rn;
  grwf_pkg::job_t q_mem [grwf_pkg::QDepth];
  grwf_pkg::job_t job_new;
  logic [grwf_pkg::QPtrW-1:0] wp_q, rp_q;
  logic [grwf_pkg::QPtrW:0] cnt_q;
  logic acc, pop;

  always_comb begin
    w_eff = (width_i < 10'd3) ? (grwf_pkg::ColW+1)'(3) :
            (width_i > 10'(grwf_pkg::MaxWidth)) ? (grwf_pkg::ColW+1)'(grwf_pkg::MaxWidth) :
            (grwf_pkg::ColW+1)'(width_i);
    h_eff = (height_i < 11'd3) ? (grwf_pkg::RowW+1)'(3) :
            (height_i > 11'(grwf_pkg::MaxHeight)) ? (grwf_pkg::RowW+1)'(grwf_pkg::MaxHeight) :
            (grwf_pkg::RowW+1)'(height_i);
    r = row_q;
    c = col_q;
    if (frame_start_i) begin
      r = '0;
      c = '0;
    end
    if (c >= w_eff) begin
      c = '0;
      r = r + 1'b1;
    end
    if (r >= h_eff) begin
      r = '0;
    end
    cn = c + 1'b1;
    rn = r;
    if (cn >= w_eff) begin
      cn = '0;
      rn = r + 1'b1;
      if (rn >= h_eff) begin
        rn = '0;
      end
    end
    col_d = cn;
    row_d = rn;
    job_new.t19 = in_data_i[15:0];
    job_new.t22 = in_data_i[31:16];
    job_new.t37 = in_data_i[47:32];
    job_new.conc = in_data_i[55:48];
    job_new.row = r[grwf_pkg::RowW-1:0];
    job_new.col = c[grwf_pkg::ColW-1:0];
    job_new.has_prev = (r != '0);
    job_new.is_last_row = (r + 1'b1 == h_eff);
  end

  assign in_ready_o = (cnt_q != (grwf_pkg::QPtrW+1)'(grwf_pkg::QDepth));
  assign acc = in_valid_i && in_ready_o;
  assign job_valid_o = (cnt_q != '0);
  assign pop = job_valid_o && job_ready_i;
  assign job_o = q_mem[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
        wp_q <= wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (grwf_pkg::QPtrW+1)'(acc) - (grwf_pkg::QPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      q_mem[wp_q] <= job_new;
    end
  end
endmodule

// ===== hw/rtl/grwf_back.sv =====
// back end: ratio divider, line stores, weather decision and result emission
module grwf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_ready_o,
  input  grwf_pkg::job_t        job_i,
  input  logic [9:0]            width_i,
  input  logic [15:0]           lim37_i,
  input  logic [15:0]           lim22_i,
  input  logic [7:0]            weather_i,
  input  logic [7:0]            bad_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output grwf_pkg::res_t        res_o
);
  localparam int ColW = grwf_pkg::ColW;
  localparam int Steps = grwf_pkg::DivSteps;

  grwf_pkg::bk_state_e st_q, st_d;
  grwf_pkg::job_t job_q;
  logic [ColW:0] w_eff;
  // two dividers run side by side, restoring, one quotient bit a cycle
  logic [16:0] den37_q, den22_q;
  logic [16:0] rem37_q, rem22_q;
  logic [15:0] q37_q, q22_q;
  logic neg37_q, neg22_q, z37_q, z22_q;
  logic [4:0] step_q;
  logic [15:0] g37, g22;
  // result slots
  grwf_pkg::res_t out_q [2];
  logic [1:0] ovld_q;
  logic osel_q;
  // stores
  logic [ColW-1:0] pr_addr, ol_addr;
  logic [39:0] pr_rd, pr_wd;
  logic [23:0] ol_rd, ol_wd;
  logic [39:0] pr_c_q;
  logic [23:0] ol_c_q;
  logic rd_phase_q;
  logic pr_we, ol_we;
  logic [ColW-1:0] c;
  logic in_c;
  logic signed [16:0] sum_n, sum_o, sum_l, sum_r, twice;
  logic signed [15:0] gc, gc22;
  logic nb, hit37, hit22, interior, act;
  logic [7:0] outc;
  logic [1:0] c37;
  grwf_pkg::res_t r0, r1;

  assign w_eff = (width_i < 10'd3) ? (ColW+1)'(3) :
                 (width_i > 10'(grwf_pkg::MaxWidth)) ? (ColW+1)'(grwf_pkg::MaxWidth) :
                 (ColW+1)'(width_i);
  assign c = job_q.col;
  assign in_c = ({1'b0, c} + 1'b1 < w_eff);

  grwf_ram #(.Width(40), .Depth(grwf_pkg::MaxWidth)) u_prev (
    .clk_i, .we_i(pr_we), .waddr_i(c), .wdata_i(pr_wd), .raddr_i(pr_addr), .rdata_o(pr_rd)
  );
  grwf_ram #(.Width(24), .Depth(grwf_pkg::MaxWidth)) u_old (
    .clk_i, .we_i(ol_we), .waddr_i(c), .wdata_i(ol_wd), .raddr_i(ol_addr), .rdata_o(ol_rd)
  );

  // center is addressed while dividing, right/left in the first read cycle,
  // so the second read cycle sees all neighbors at once
  assign pr_addr = (st_q == grwf_pkg::BkRead && !rd_phase_q) ? ColW'(c + 1'b1) : c;
  assign ol_addr = (st_q == grwf_pkg::BkRead && !rd_phase_q) ? ColW'(c - 1'b1) : c;

  assign g37 = z37_q ? 16'd0 : (neg37_q ? 16'(-q37_q) : q37_q);
  assign g22 = z22_q ? 16'd0 : (neg22_q ? 16'(-q22_q) : q22_q);

  always_comb begin
    interior = (job_q.row >= grwf_pkg::RowW'(2)) && (c != '0) && in_c;
    gc = pr_c_q[31:16];
    gc22 = pr_c_q[15:0];
    twice = {lim37_i[15], lim37_i};
    twice = twice <<< 1;
    sum_n = {gc[15], gc} + {g37[15], g37};
    sum_o = {gc[15], gc} + {ol_c_q[15], ol_c_q[15:0]};
    sum_l = {gc[15], gc} + (c != '0 ? {ol_rd[15], ol_rd[15:0]} : {gc[15], gc});
    sum_r = {gc[15], gc} + (in_c ? {pr_rd[31], pr_rd[31:16]} : {gc[15], gc});
    act = interior && pr_c_q[39:32] != 8'd0 && pr_c_q[39:32] != bad_i;
    hit37 = $signed(gc) > $signed(lim37_i);
    hit22 = $signed(gc22) > $signed(lim22_i);
    nb = (job_q.conc != bad_i && sum_n > twice) ||
         (ol_c_q[23:16] != bad_i && sum_o > twice) ||
         (((c != '0) ? ol_rd[23:16] : pr_c_q[39:32]) != bad_i && sum_l > twice) ||
         ((in_c ? pr_rd[39:32] : pr_c_q[39:32]) != bad_i && sum_r > twice);
    c37 = act ? (2'(hit37) + 2'(nb)) : 2'd0;
    outc = (act && (hit37 || hit22 || nb)) ? weather_i : pr_c_q[39:32];
    r0.conc = outc;
    r0.row = job_q.row - 1'b1;
    r0.col = c;
    r0.c37 = c37;
    r0.c22 = act && hit22;
    r0.last = !job_q.is_last_row;
    r1.conc = job_q.conc;
    r1.row = job_q.row;
    r1.col = c;
    r1.c37 = 2'd0;
    r1.c22 = 1'b0;
    r1.last = 1'b1;
    pr_wd = {job_q.conc, g37, g22};
    ol_wd = {out_q[0].conc, gc};
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      grwf_pkg::BkIdle: if (job_valid_i) st_d = grwf_pkg::BkDiv;
      grwf_pkg::BkDiv: if (step_q == 5'(Steps - 1)) begin
        st_d = job_q.has_prev ? grwf_pkg::BkRead : grwf_pkg::BkOut;
      end
      grwf_pkg::BkRead: if (rd_phase_q) st_d = grwf_pkg::BkOut;
      grwf_pkg::BkOut: if (ovld_q == 2'b00) st_d = grwf_pkg::BkIdle;
      default: st_d = grwf_pkg::BkIdle;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    job_ready_o = (st_q == grwf_pkg::BkIdle);
    pr_we = 1'b0;
    ol_we = 1'b0;
    case (st_q)
      grwf_pkg::BkRead: begin
        pr_we = 1'b0;
      end
      grwf_pkg::BkOut: begin
        pr_we = (ovld_q == 2'b00);
        ol_we = (ovld_q == 2'b00) && job_q.has_prev;
      end
      default: begin
        pr_we = 1'b0;
      end
    endcase
  end

  assign res_valid_o = ovld_q[osel_q];
  assign res_o = out_q[osel_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= grwf_pkg::BkIdle;
      step_q <= '0;
      rd_phase_q <= 1'b0;
      ovld_q <= 2'b00;
      osel_q <= 1'b0;
    end else begin
      st_q <= st_d;
      case (st_q)
        grwf_pkg::BkIdle: step_q <= '0;
        grwf_pkg::BkDiv: step_q <= step_q + 1'b1;
        grwf_pkg::BkRead: rd_phase_q <= ~rd_phase_q;
        default: step_q <= step_q;
      endcase
      if (st_d == grwf_pkg::BkOut && st_q != grwf_pkg::BkOut) begin
        ovld_q <= {job_q.is_last_row, job_q.has_prev};
        osel_q <= !job_q.has_prev;
      end else if (res_valid_o && res_ready_i) begin
        ovld_q[osel_q] <= 1'b0;
        osel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == grwf_pkg::BkIdle && job_valid_i) begin
      job_q <= job_i;
      z37_q <= (job_i.t37 == 16'd0) || (job_i.t19 == 16'd0);
      z22_q <= (job_i.t22 == 16'd0) || (job_i.t19 == 16'd0);
      neg37_q <= job_i.t37 < job_i.t19;
      neg22_q <= job_i.t22 < job_i.t19;
      // difference is below the sum when neither input is zero, so it is the first partial remainder
      rem37_q <= {1'b0, (job_i.t37 >= job_i.t19) ? job_i.t37 - job_i.t19
                                                : job_i.t19 - job_i.t37};
      rem22_q <= {1'b0, (job_i.t22 >= job_i.t19) ? job_i.t22 - job_i.t19
                                                : job_i.t19 - job_i.t22};
      den37_q <= {1'b0, job_i.t37} + {1'b0, job_i.t19};
      den22_q <= {1'b0, job_i.t22} + {1'b0, job_i.t19};
      q37_q <= '0;
      q22_q <= '0;
    end
    if (st_q == grwf_pkg::BkDiv) begin
      // shift in a zero, try subtract
      if ({rem37_q, 1'b0} >= {1'b0, den37_q}) begin
        rem37_q <= 17'({rem37_q, 1'b0} - {1'b0, den37_q});
        q37_q <= {q37_q[14:0], 1'b1};
      end else begin
        rem37_q <= {rem37_q[15:0], 1'b0};
        q37_q <= {q37_q[14:0], 1'b0};
      end
      if ({rem22_q, 1'b0} >= {1'b0, den22_q}) begin
        rem22_q <= 17'({rem22_q, 1'b0} - {1'b0, den22_q});
        q22_q <= {q22_q[14:0], 1'b1};
      end else begin
        rem22_q <= {rem22_q[15:0], 1'b0};
        q22_q <= {q22_q[14:0], 1'b0};
      end
    end
    if (st_q == grwf_pkg::BkRead) begin
      if (!rd_phase_q) begin
        pr_c_q <= pr_rd;
        ol_c_q <= ol_rd;
      end
    end
    if (st_d == grwf_pkg::BkOut && st_q != grwf_pkg::BkOut) begin
      out_q[0] <= r0;
      out_q[1] <= r1;
    end
  end
endmodule

// ===== hw/rtl/gradient_ratio_weather_filter_core.sv =====
// the back end takes a new pixel only when idle: each pixel passes the 15-step serial
// ratio divider and the line store reads (not on row 0), then waits until its words are
// taken and the line stores are written; the front end queues up to four pixels
// results for row r come out when row r+1 arrives; the last row adds a second word
// reset: asynchronous active low, clears position, queue and control state
// line stores are not cleared; they are written before read within a frame
module gradient_ratio_weather_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // temp_19v, temp_22v, temp_37v, conc_in
  input  logic        s_axis_tuser,  // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // conc_out, row_out, col_out, count37_add, count22_add
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [9:0] width_q;
  logic [10:0] height_q;
  logic [15:0] lim37_q, lim22_q;
  logic [7:0] weather_q, bad_q;
  logic job_valid, job_ready;
  grwf_pkg::job_t job;
  grwf_pkg::res_t res;
  grwf_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign idx = grwf_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 10'd304;
      height_q <= 11'd448;
      lim37_q <= 16'd1638;
      lim22_q <= 16'd1475;
      weather_q <= 8'd177;
      bad_q <= 8'd166;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        grwf_pkg::RegWidth: width_q <= pwdata[9:0];
        grwf_pkg::RegHeight: height_q <= pwdata[10:0];
        grwf_pkg::RegLim37: lim37_q <= pwdata[15:0];
        grwf_pkg::RegLim22: lim22_q <= pwdata[15:0];
        grwf_pkg::RegWeather: weather_q <= pwdata[7:0];
        grwf_pkg::RegBad: bad_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      grwf_pkg::RegWidth: prdata = {22'd0, width_q};
      grwf_pkg::RegHeight: prdata = {21'd0, height_q};
      grwf_pkg::RegLim37: prdata = {16'd0, lim37_q};
      grwf_pkg::RegLim22: prdata = {16'd0, lim22_q};
      grwf_pkg::RegWeather: prdata = {24'd0, weather_q};
      grwf_pkg::RegBad: prdata = {24'd0, bad_q};
      default: prdata = 32'd0;
    endcase
  end

  grwf_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata), .frame_start_i(s_axis_tuser),
    .width_i(width_q), .height_i(height_q),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  grwf_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .width_i(width_q), .lim37_i(lim37_q), .lim22_i(lim22_q),
    .weather_i(weather_q), .bad_i(bad_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {2'd0, res.c22, res.c37, res.col, res.row, res.conc};
  assign m_axis_tlast = res.last;
endmodule

// ===== hw/rtl/grwf_checker.sv =====
// port-level checks for the weather filter core
module grwf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        pready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:30] == 2'd0)
    else $error("pad bits set");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[28:27] != 2'd3)
    else $error("count37 out of range");
  a_rdy: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule

bind gradient_ratio_weather_filter_core grwf_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .pready
);

// ===== bench/gradient_ratio_weather_filter_core_tb.sv =====
// testbench for the gradient ratio weather filter core: random rasters checked against a predictor
module gradient_ratio_weather_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 200;

  typedef struct {
    logic [15:0] t19;
    logic [15:0] t22;
    logic [15:0] t37;
    logic [7:0]  conc;
    logic        frame_start;
  } pixel_t;

  typedef struct {
    logic [7:0] conc;
    logic [9:0] row;
    logic [8:0] col;
    logic [1:0] c37;
    logic       c22;
    logic       last;
  } filtered_t;

  typedef struct {
    logic [7:0] conc;
    int         g37;
    int         g22;
  } line_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // temp_19v, temp_22v, temp_37v, conc_in
  logic        s_axis_tuser = 1'b0;  // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // conc_out, row_out, col_out, count37_add, count22_add
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gradient_ratio_weather_filter_core dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // filter settings as the predictor sees them
  logic [9:0]  cfg_width = 10'd304;
  logic [10:0] cfg_height = 11'd448;
  logic [15:0] cfg_lim37 = 16'd1638;
  logic [15:0] cfg_lim22 = 16'd1475;
  logic [7:0]  cfg_weather = 8'd177;
  logic [7:0]  cfg_bad = 8'd166;

  line_entry_t latest_row [grwf_pkg::MaxWidth];
  line_entry_t filtered_row [grwf_pkg::MaxWidth];
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;

  pixel_t    pending_pixels[$];
  filtered_t expected_words[$];
  pixel_t    in_flight;
  bit        quiet = 1'b0;
  int        n_err = 0;
  int        n_in = 0;
  int        n_out = 0;
  int        n_weather = 0;
  int        idle_cycles = 0;

  function automatic int grad_ratio(logic [15:0] hi, logic [15:0] lo);
    longint d;
    longint q;
    if (hi == 0 || lo == 0) return 0;
    d = (hi > lo) ? longint'(hi) - longint'(lo) : longint'(lo) - longint'(hi);
    q = (d << grwf_pkg::FracBits) / (longint'(hi) + longint'(lo));
    return (hi >= lo) ? int'(q) : -int'(q);
  endfunction

  task automatic predict_pixel(pixel_t p);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int          l37;
    int          l22;
    longint      twice;
    longint      g;
    int          g37_now;
    int          g22_now;
    line_entry_t mid;
    line_entry_t left;
    line_entry_t right;
    filtered_t   res;
    bit          interior;
    bit          nb;
    begin
      w = cfg_width;
      h = cfg_height;
      if (w < 3) w = 3;
      if (w > grwf_pkg::MaxWidth) w = grwf_pkg::MaxWidth;
      if (h < 3) h = 3;
      if (h > grwf_pkg::MaxHeight) h = grwf_pkg::MaxHeight;
      l37 = $signed(cfg_lim37);
      l22 = $signed(cfg_lim22);
      twice = 2 * longint'(l37);
      r = pos_row;
      c = pos_col;
      if (p.frame_start) begin
        r = 0;
        c = 0;
      end
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      g37_now = grad_ratio(p.t37, p.t19);
      g22_now = grad_ratio(p.t22, p.t19);
      if (r >= 1) begin
        mid = latest_row[c];
        left = (c >= 1) ? filtered_row[c-1] : mid;
        right = (c + 1 < w) ? latest_row[c+1] : mid;
        interior = (r >= 2) && (c >= 1) && (c + 1 < w);
        res = '{conc: mid.conc, row: r - 1, col: c, c37: 0, c22: 0, last: (r + 1 != h)};
        if (interior && mid.conc != 0 && mid.conc != cfg_bad) begin
          g = mid.g37;
          nb = 1'b0;
          if (g > l37) res.c37++;
          if (mid.g22 > l22) res.c22 = 1'b1;
          if (p.conc != cfg_bad && g + g37_now > twice) nb = 1'b1;
          if (filtered_row[c].conc != cfg_bad && g + filtered_row[c].g37 > twice) nb = 1'b1;
          if (left.conc != cfg_bad && g + left.g37 > twice) nb = 1'b1;
          if (right.conc != cfg_bad && g + right.g37 > twice) nb = 1'b1;
          if (nb) res.c37++;
          if (res.c37 != 0 || res.c22) begin
            res.conc = cfg_weather;
            n_weather++;
          end
        end
        filtered_row[c] = '{conc: res.conc, g37: mid.g37, g22: mid.g22};
        expected_words.push_back(res);
      end
      latest_row[c] = '{conc: p.conc, g37: g37_now, g22: g22_now};
      if (r + 1 == h)
        expected_words.push_back('{conc: p.conc, row: r, col: c, c37: 0, c22: 0, last: 1});
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      pos_col = c;
      pos_row = r;
    end
  endtask

  // driver: offers pending pixels with random gaps
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pixel(in_flight);
        n_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          in_flight = pending_pixels.pop_front();
          s_axis_tdata <= {in_flight.conc, in_flight.t37, in_flight.t22, in_flight.t19};
          s_axis_tuser <= in_flight.frame_start;
          s_axis_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 19);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (word %0d)", what, got, want, n_out);
    n_err++;
  endtask

  // monitor: random stalls plus one long hold-off to back up the block
  int  stall_left = 0;
  bit  held = 1'b0;
  filtered_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 0);
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[7:0] != want.conc)
            report_mismatch("conc", m_axis_tdata[7:0], want.conc);
          if (m_axis_tdata[17:8] != want.row)
            report_mismatch("row", m_axis_tdata[17:8], want.row);
          if (m_axis_tdata[26:18] != want.col)
            report_mismatch("col", m_axis_tdata[26:18], want.col);
          if (m_axis_tdata[28:27] != want.c37)
            report_mismatch("count37", m_axis_tdata[28:27], want.c37);
          if (m_axis_tdata[29] != want.c22)
            report_mismatch("count22", m_axis_tdata[29], want.c22);
          if (m_axis_tlast != want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        end
        n_out++;
      end
      if (!held && n_out == 40) begin
        held = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("[gradient_ratio_weather_filter_core] ERROR");
      $finish;
    end
  end

  task automatic write_reg(grwf_pkg::reg_idx_e idx, logic [31:0] value);
    begin
      @(posedge clk_i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
        grwf_pkg::RegWidth:   cfg_width = value[9:0];
        grwf_pkg::RegHeight:  cfg_height = value[10:0];
        grwf_pkg::RegLim37:   cfg_lim37 = value[15:0];
        grwf_pkg::RegLim22:   cfg_lim22 = value[15:0];
        grwf_pkg::RegWeather: cfg_weather = value[7:0];
        grwf_pkg::RegBad:     cfg_bad = value[7:0];
        default: ;
      endcase
    end
  endtask

  task automatic setup(int w, int h, int l37, int l22, int wc, int bc);
    begin
      while (pending_pixels.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
        @(posedge clk_i);
      // row 0 pixels give no word but may still sit in the divider
      repeat (DrainCycles) @(posedge clk_i);
      write_reg(grwf_pkg::RegWidth, w);
      write_reg(grwf_pkg::RegHeight, h);
      write_reg(grwf_pkg::RegLim37, l37 & 16'hFFFF);
      write_reg(grwf_pkg::RegLim22, l22 & 16'hFFFF);
      write_reg(grwf_pkg::RegWeather, wc);
      write_reg(grwf_pkg::RegBad, bc);
    end
  endtask

  function automatic logic [15:0] near_temp(logic [15:0] base);
    int off;
    int v;
    off = $urandom_range(0, base >> 2);
    v = $urandom_range(0, 1) ? int'(base) + off : int'(base) - off;
    if (v > 65535) v = 65535;
    if (v < 1) v = 1;
    return v[15:0];
  endfunction

  function automatic pixel_t random_pixel(bit fs);
    pixel_t p;
    p.t19 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1000, 65535);
    p.t22 = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : near_temp(p.t19);
    p.t37 = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : near_temp(p.t19);
    if ($urandom_range(0, 15) == 0) p.t19 = 0;
    if ($urandom_range(0, 15) == 0) p.t22 = 0;
    if ($urandom_range(0, 15) == 0) p.t37 = 0;
    case ($urandom_range(0, 7))
      0: p.conc = 8'd0;
      1: p.conc = cfg_bad;
      2: p.conc = cfg_weather;
      default: p.conc = $urandom_range(0, 255);
    endcase
    p.frame_start = fs || ($urandom_range(0, 199) == 0);
    return p;
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return $urandom_range(0, 65535) - 32768;
      default: return $urandom_range(0, 6000) - 1000;
    endcase
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) pending_pixels.push_back(random_pixel(i == 0));
  endtask

  logic [15:0] corner_temps [6] = '{16'd0, 16'd1, 16'd65535, 16'd32768, 16'd30000, 16'd31000};

  initial begin
    pixel_t p;
    for (int i = 0; i < grwf_pkg::MaxWidth; i++) begin
      latest_row[i] = '{conc: 0, g37: 0, g22: 0};
      filtered_row[i] = '{conc: 0, g37: 0, g22: 0};
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corner temperatures and codes on a 4x3 grid, one cut frame
    setup(4, 3, 1638, 1475, 177, 166);
    for (int i = 0; i < 24; i++) begin
      p.t19 = corner_temps[i % 6];
      p.t22 = corner_temps[(i / 2) % 6];
      p.t37 = corner_temps[(i * 5 + 1) % 6];
      case (i % 4)
        0: p.conc = 8'd0;
        1: p.conc = 8'd166;
        2: p.conc = 8'd255;
        default: p.conc = 8'd60;
      endcase
      p.frame_start = (i == 0) || (i == 17);
      pending_pixels.push_back(p);
    end

    // widest and tallest grid, only the first rows
    setup(512, 1024, 1638, 1475, 177, 166);
    add_random(600);
    setup(3, 3, 32767, -32768, 0, 255);
    add_random(90);
    setup(3, 1024, -32768, 32767, 255, 0);
    add_random(60);
    for (int ph = 0; ph < 10; ph++) begin
      setup($urandom_range(3, 8), $urandom_range(3, 6), pick_limit(), pick_limit(),
            $urandom_range(0, 255), $urandom_range(0, 255));
      if (ph == 9) quiet = 1'b1;
      add_random(110);
    end

    while (pending_pixels.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("pixels sent %0d, words checked %0d, weather-flagged %0d",
             n_in, n_out, n_weather);
    $display("grids from 3x3 up to 512x1024, limits at both ends, cut frames, long stall");
    if (n_err == 0) begin
      $display("[gradient_ratio_weather_filter_core] OK");
    end else begin
      $display("[gradient_ratio_weather_filter_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== gradient_ratio_weather_filter_core.f =====
hw/rtl/grwf_pkg.sv
hw/rtl/grwf_ram.sv
hw/rtl/grwf_front.sv
hw/rtl/grwf_back.sv
hw/rtl/gradient_ratio_weather_filter_core.sv
hw/rtl/grwf_checker.sv
bench/gradient_ratio_weather_filter_core_tb.sv
